[sv/sqm_pkg.sv]
// constants, types and match function for the sensitive query matcher
// no dependencies; used by the interfaces, the cell and the top level
package sqm_pkg;

    localparam int HIST_DEPTH = 30;
    localparam int NAME_COUNT = 9;
    localparam int NAME_BYTES = 32;
    localparam int OFS_W      = $clog2(HIST_DEPTH + 1);
    localparam int LEN_W      = $clog2(NAME_BYTES + 1);
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 32;

    // last character of each name sits in bits [7:0]
    localparam logic [NAME_COUNT-1:0][NAME_BYTES*8-1:0] NAMES = {
        (NAME_BYTES*8)'({"current_", "setting('is_", "super", "user')"}),
        (NAME_BYTES*8)'({"information_", "schema.role_"}),
        (NAME_BYTES*8)'({"information_", "schema.user_"}),
        (NAME_BYTES*8)'({"pg_stat_user_", "indexes"}),
        (NAME_BYTES*8)'({"pg_stat_user_", "tables"}),
        (NAME_BYTES*8)'({"pg_", "roles"}),
        (NAME_BYTES*8)'("pg_user"),
        (NAME_BYTES*8)'({"pg_", "authid"}),
        (NAME_BYTES*8)'({"pg_", "shadow"})
    };

    localparam logic [NAME_COUNT-1:0][LEN_W-1:0] NAME_LEN = {
        LEN_W'(31), LEN_W'(24), LEN_W'(24), LEN_W'(20), LEN_W'(19),
        LEN_W'(8),  LEN_W'(7),  LEN_W'(9),  LEN_W'(9)
    };

    typedef struct packed {
        logic shift;
        logic clear;
    } sqm_cell_ctl_t;

    typedef logic [NAME_COUNT-1:0] sqm_hit_t;

    // per name: byte agrees with the name character at offset ofs from its end,
    // or the name is shorter than that and does not care
    function automatic sqm_hit_t char_match(input logic [BYTE_W-1:0] b,
                                            input logic [OFS_W-1:0]  ofs);
        sqm_hit_t res;
        res = '0;
        for (int n = 0; n < NAME_COUNT; n++) begin
            if (LEN_W'(ofs) >= NAME_LEN[n])
            begin
                res[n] = 1'b1;
            end
            else
            begin
                res[n] = (b == NAMES[n][{ofs, 3'b000} +: BYTE_W]);
            end
        end
        return res;
    endfunction

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] res;
        res = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            res = c + 8'h20;
        end
        return res;
    endfunction

endpackage

[sv/sqm_in_if.sv]
// query byte channel: valid/ready with byte, source and last mark
// depends on sqm_pkg
interface sqm_in_if;
    logic                        valid;
    logic                        ready;
    logic [sqm_pkg::BYTE_W-1:0]  query_byte;
    logic [sqm_pkg::ADDR_W-1:0]  source_addr;
    logic                        last_byte;

    modport source (output valid, output query_byte, output source_addr,
                    output last_byte, input ready);
    modport sink   (input valid, input query_byte, input source_addr,
                    input last_byte, output ready);
endinterface

[sv/sqm_out_if.sv]
// result channel: valid/ready with source and suspicious flag
// depends on sqm_pkg
interface sqm_out_if;
    logic                        valid;
    logic                        ready;
    logic [sqm_pkg::ADDR_W-1:0]  flagged_source;
    logic                        suspicious;

    modport source (output valid, output flagged_source, output suspicious,
                    input ready);
    modport sink   (input valid, input flagged_source, input suspicious,
                    output ready);
endinterface

[sv/sqm_cell.sv]
// one window cell: holds a history byte, passes it on, compares it to all names
// depends on sqm_pkg
module sqm_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sqm_pkg::sqm_cell_ctl_t      ctl,
    input  logic [sqm_pkg::OFS_W-1:0]   offset,
    input  logic [sqm_pkg::BYTE_W-1:0]  byte_in,
    output logic [sqm_pkg::BYTE_W-1:0]  byte_out,
    output sqm_pkg::sqm_hit_t           hit
);

    logic [sqm_pkg::BYTE_W-1:0] byte_reg;
    logic [sqm_pkg::BYTE_W-1:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.clear)
        begin
            byte_next = '0;
        end
        else if (ctl.shift)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;
    assign hit      = sqm_pkg::char_match(byte_reg, offset);

endmodule

[sv/sensitive_query_matcher.sv]
// sensitive query matcher: one byte per cycle unless a last beat stalls, result in the cycle after the last beat
// latency: the result of a query is valid in the cycle after its last byte is taken
// throughput: one byte per cycle while no last beat stalls on a busy output; set by the single row of window cells
// the output register lets the next byte in while a result waits to be taken
// reset clears the window cells, the hit flag and the output valid
// depends on sqm_pkg, sqm_in_if, sqm_out_if, sqm_cell
module sensitive_query_matcher (
    input  logic         clk,
    input  logic         rst_n,
    sqm_in_if.sink       query_in,
    sqm_out_if.source    result_out
);

    logic                        in_fire;
    logic [sqm_pkg::BYTE_W-1:0]  cur_byte;
    sqm_pkg::sqm_cell_ctl_t      cell_ctl;
    sqm_pkg::sqm_hit_t           cur_hit;
    sqm_pkg::sqm_hit_t           name_ok;
    sqm_pkg::sqm_hit_t           cell_hit [sqm_pkg::HIST_DEPTH];
    logic [sqm_pkg::BYTE_W-1:0]  cell_byte [sqm_pkg::HIST_DEPTH];
    logic                        any_hit;

    logic                        hit_seen_reg;
    logic                        hit_seen_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [sqm_pkg::ADDR_W-1:0]  flagged_source_reg;
    logic                        suspicious_reg;

    // only a last beat needs the output register free
    assign query_in.ready = !out_valid_reg || result_out.ready || !query_in.last_byte;
    assign in_fire        = query_in.valid && query_in.ready;
    assign cur_byte       = sqm_pkg::fold_byte(query_in.query_byte);

    assign cell_ctl.shift = in_fire && !query_in.last_byte;
    assign cell_ctl.clear = in_fire && query_in.last_byte;

    // cell i holds the byte i+1 positions before the current one
    for (genvar i = 0; i < sqm_pkg::HIST_DEPTH; i++) begin : g_cell
        sqm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl),
            .offset   (sqm_pkg::OFS_W'(i + 1)),
            .byte_in  ((i == 0) ? cur_byte : cell_byte[(i == 0) ? 0 : i - 1]),
            .byte_out (cell_byte[i]),
            .hit      (cell_hit[i])
        );
    end

    assign cur_hit = sqm_pkg::char_match(cur_byte, '0);

    always_comb
    begin
        name_ok = cur_hit;
        for (int i = 0; i < sqm_pkg::HIST_DEPTH; i++) begin
            name_ok = name_ok & cell_hit[i];
        end
    end

    assign any_hit = |name_ok;

    always_comb
    begin
        hit_seen_next = hit_seen_reg;
        if (in_fire)
        begin
            hit_seen_next = query_in.last_byte ? 1'b0 : (hit_seen_reg | any_hit);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cell_ctl.clear)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hit_seen_reg  <= hit_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded on the last beat of a query
    always_ff @(posedge clk)
    begin
        if (cell_ctl.clear)
        begin
            flagged_source_reg <= query_in.source_addr;
            suspicious_reg     <= hit_seen_reg | any_hit;
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.flagged_source = flagged_source_reg;
    assign result_out.suspicious     = suspicious_reg;

endmodule
